// ===== hw/rtl/normalized_poly_eval_defines.svh =====
// Assertion macros shared by the normalized polynomial evaluator.
`ifndef NORMALIZED_POLY_EVAL_DEFINES_SVH
`define NORMALIZED_POLY_EVAL_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked at every rising clock edge outside reset.
`define NPE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("normalized_poly_eval: check failed");
// Next-cycle implication, checked at every rising clock edge outside reset.
`define NPE_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("normalized_poly_eval: check failed");
`else
`define NPE_ASSERT_IMP(lbl, ante, cons)
`define NPE_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== hw/rtl/npe_pkg.sv =====
// Types, constants and helpers for the normalized polynomial evaluator.
`default_nettype none

package npe_pkg;

    localparam int MAX_TERMS  = 16;
    localparam int FRAC_BITS  = 16;
    localparam int WORD_W     = 32;
    localparam int ORDER_W    = 4;
    localparam int ADDR_W     = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int DIFF_W     = WORD_W + 1;
    localparam int DVD_W      = DIFF_W + FRAC_BITS;
    localparam int DVD_CNT_W  = $clog2(DVD_W);
    localparam int APB_ADDR_W = 4;

    localparam logic signed [WORD_W-1:0] Q_ONE    = WORD_W'(64'd1 << FRAC_BITS);
    localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [63:0] WIDE_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] WIDE_MIN = -64'sh0000_0000_8000_0000;
    localparam logic signed [WORD_W-1:0] NORM_RESET = 32'sh0001_0000;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_ORDER = 2'd0;
    localparam logic [1:0] REG_MEAN  = 2'd1;
    localparam logic [1:0] REG_NORM  = 2'd2;

    // Item operations.
    localparam logic OP_EVAL  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef struct packed {
        logic                     operation;
        logic signed [WORD_W-1:0] position;
        logic [ORDER_W-1:0]       coeff_index;
        logic signed [WORD_W-1:0] coeff_value;
    } item_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] value;
        logic                     norm_zero;
        logic                     saturated;
    } result_t;

    // Clipped word plus the flag that says it was clipped.
    typedef struct packed {
        logic                     sat;
        logic signed [WORD_W-1:0] value;
    } word_res_t;

    typedef struct packed {
        logic                     done;
        logic                     sat;
        logic signed [WORD_W-1:0] quotient;
    } div_res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_MC,
        ST_MP,
        ST_ACC,
        ST_PWR,
        ST_DONE
    } npe_state_t;

    function automatic word_res_t clip_word(input logic signed [63:0] v);
        word_res_t r;
        if (v > WIDE_MAX)
        begin
            r.sat   = 1'b1;
            r.value = WORD_MAX;
        end
        else if (v < WIDE_MIN)
        begin
            r.sat   = 1'b1;
            r.value = WORD_MIN;
        end
        else
        begin
            r.sat   = 1'b0;
            r.value = v[WORD_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/normalized_poly_eval.sv =====
// Top level of the normalized polynomial evaluator in signed Q16.16.
//
//   Port group      Handshake                      Payload
//   item            item_valid / item_ready        item   (npe_pkg::item_t)
//   result          result_valid / result_ready    result (npe_pkg::result_t)
//   configuration   psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// A coefficient write gives no result.
// An evaluation first runs the divider, which retires one quotient bit a cycle
// (49 steps); then each term passes states MC, MP, ACC and PWR on the shared
// multiplier. A zero norm skips both. One item is worked on at a time.
// Reset clears control registers and coefficient valid bits; no clearing pass is needed.
// A finished result waits in the output register while the next item is taken in.
`default_nettype none

`include "normalized_poly_eval_defines.svh"

module normalized_poly_eval (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  item_valid,
    output logic                                       item_ready,
    input  wire npe_pkg::item_t                        item,
    output logic                                       result_valid,
    input  wire logic                                  result_ready,
    output npe_pkg::result_t                           result,
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [npe_pkg::APB_ADDR_W-1:0]        paddr,
    input  wire logic [31:0]                           pwdata,
    output logic      [31:0]                           prdata,
    output logic                                       pready
);
    import npe_pkg::*;

    npe_state_t state_reg;
    npe_state_t state_next;

    logic [ORDER_W-1:0]       poly_order_reg;
    logic signed [WORD_W-1:0] mean_offset_reg;
    logic signed [WORD_W-1:0] norm_scale_reg;
    logic [MAX_TERMS-1:0]     valid_reg;

    logic [ADDR_W-1:0]        idx_reg;
    logic [ADDR_W-1:0]        last_idx_reg;
    logic signed [WORD_W-1:0] u_reg;
    logic signed [WORD_W-1:0] power_reg;
    logic signed [WORD_W-1:0] sum_reg;
    logic                     sat_reg;
    logic                     nz_reg;
    logic                     coef_ok_reg;

    result_t result_reg;
    logic    result_valid_reg;

    logic                     cfg_wr;
    logic                     item_acc;
    logic                     eval_acc;
    logic                     coef_wr;
    logic                     div_start;
    logic signed [DIFF_W-1:0] diff;
    div_res_t                 div_res;
    word_res_t                mul_res;
    logic signed [WORD_W-1:0] mul_a;
    logic signed [WORD_W-1:0] mul_b;
    logic [WORD_W-1:0]        ram_rdata;
    logic signed [WORD_W-1:0] coef;
    logic                     rd_en;
    logic [ADDR_W-1:0]        rd_addr;
    logic [ADDR_W-1:0]        wr_addr;
    logic                     last_term;
    logic                     out_free;
    logic signed [WORD_W:0]   sum_wide;
    logic                     sum_ovf;
    logic signed [WORD_W-1:0] sum_clip;

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poly_order_reg  <= '0;
            mean_offset_reg <= '0;
            norm_scale_reg  <= NORM_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_ORDER: poly_order_reg  <= pwdata[ORDER_W-1:0];
                REG_MEAN:  mean_offset_reg <= pwdata;
                REG_NORM:  norm_scale_reg  <= pwdata;
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_ORDER: prdata = {{(32 - ORDER_W){1'b0}}, poly_order_reg};
            REG_MEAN:  prdata = mean_offset_reg;
            REG_NORM:  prdata = norm_scale_reg;
            default:   prdata = '0;
        endcase
    end

    // Item side.
    assign item_ready = (state_reg == ST_IDLE);
    assign item_acc   = item_valid && item_ready;
    assign eval_acc   = item_acc && (item.operation == OP_EVAL);
    assign coef_wr    = item_acc && (item.operation == OP_WRITE)
                        && (32'(item.coeff_index) < 32'(MAX_TERMS));
    assign div_start  = eval_acc && (norm_scale_reg != '0);
    assign diff       = {item.position[WORD_W-1], item.position}
                        - {mean_offset_reg[WORD_W-1], mean_offset_reg};
    assign wr_addr    = ADDR_W'(item.coeff_index);

    // The first coefficient is fetched while dividing, the next one while the
    // power product is issued.
    assign rd_en   = (state_reg == ST_DIV) || (state_reg == ST_MP);
    assign rd_addr = (state_reg == ST_MP) ? (idx_reg + ADDR_W'(1)) : idx_reg;
    assign coef    = coef_ok_reg ? $signed(ram_rdata) : '0;

    assign mul_a = power_reg;
    assign mul_b = (state_reg == ST_MC) ? coef : u_reg;

    assign last_term = (idx_reg == last_idx_reg);
    assign out_free  = !result_valid_reg || result_ready;

    assign sum_wide = {sum_reg[WORD_W-1], sum_reg} + {mul_res.value[WORD_W-1], mul_res.value};
    assign sum_ovf  = sum_wide[WORD_W] != sum_wide[WORD_W-1];
    assign sum_clip = sum_ovf ? (sum_wide[WORD_W] ? WORD_MIN : WORD_MAX)
                              : sum_wide[WORD_W-1:0];

    npe_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_TERMS)
    ) u_coef_ram (
        .clk   (clk),
        .we    (coef_wr),
        .waddr (wr_addr),
        .wdata (item.coeff_value),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    npe_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (diff),
        .divisor  (norm_scale_reg),
        .res      (div_res)
    );

    npe_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .res (mul_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (eval_acc)
                begin
                    state_next = (norm_scale_reg == '0) ? ST_DONE : ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_res.done)
                begin
                    state_next = ST_MC;
                end
            end
            ST_MC:   state_next = ST_MP;
            ST_MP:   state_next = ST_ACC;
            ST_ACC:  state_next = ST_PWR;
            ST_PWR:  state_next = last_term ? ST_DONE : ST_MC;
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Coefficient valid bits: an entry never written reads as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (coef_wr)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            coef_ok_reg <= (32'(rd_addr) < 32'(MAX_TERMS)) && valid_reg[rd_addr];
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (eval_acc)
                begin
                    idx_reg   <= '0;
                    power_reg <= Q_ONE;
                    sat_reg   <= 1'b0;
                    nz_reg    <= (norm_scale_reg == '0);
                    sum_reg   <= (norm_scale_reg == '0) ? Q_ONE : '0;
                    if (32'(poly_order_reg) >= 32'(MAX_TERMS - 1))
                    begin
                        last_idx_reg <= ADDR_W'(MAX_TERMS - 1);
                    end
                    else
                    begin
                        last_idx_reg <= ADDR_W'(poly_order_reg);
                    end
                end
            end
            ST_DIV:
            begin
                if (div_res.done)
                begin
                    u_reg   <= div_res.quotient;
                    sat_reg <= sat_reg | div_res.sat;
                end
            end
            ST_ACC:
            begin
                sum_reg <= sum_clip;
                sat_reg <= sat_reg | mul_res.sat | sum_ovf;
            end
            ST_PWR:
            begin
                // The power is only advanced when a further term follows.
                if (!last_term)
                begin
                    power_reg <= mul_res.value;
                    sat_reg   <= sat_reg | mul_res.sat;
                    idx_reg   <= idx_reg + ADDR_W'(1);
                end
            end
            default: ;
        endcase
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if ((state_reg == ST_DONE) && out_free)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_DONE) && out_free)
        begin
            result_reg.value     <= sum_reg;
            result_reg.norm_zero <= nz_reg;
            result_reg.saturated <= sat_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `NPE_ASSERT_IMP(a_norm_zero_result, result_valid && result.norm_zero, (result.value == Q_ONE) && !result.saturated)
    `NPE_ASSERT_IMP(a_div_done_in_div, div_res.done, state_reg == ST_DIV)
    `NPE_ASSERT_IMP(a_term_in_range, state_reg == ST_MC, idx_reg <= last_idx_reg)
    `NPE_ASSERT_NXT(a_eval_starts_div, div_start, state_reg == ST_DIV)

endmodule

`default_nettype wire

// ===== hw/rtl/npe_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none

module npe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                       clk,
    input  wire logic                                       we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                           wdata,
    input  wire logic                                       re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/npe_div.sv =====
// Restoring divider: scaled signed difference over the norm, one quotient bit a cycle.
`default_nettype none

module npe_div (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    input  wire logic signed [npe_pkg::DIFF_W-1:0]  dividend,
    input  wire logic signed [npe_pkg::WORD_W-1:0]  divisor,
    output npe_pkg::div_res_t                       res
);
    import npe_pkg::*;

    localparam logic [DVD_CNT_W-1:0] CNT_LAST = DVD_CNT_W'(DVD_W - 1);
    localparam logic [DVD_W-1:0]     POS_LIM  = DVD_W'(64'h7FFF_FFFF);
    localparam logic [DVD_W-1:0]     NEG_LIM  = DVD_W'(64'h8000_0000);

    logic                 busy_reg;
    logic                 fin_reg;
    logic [DVD_CNT_W-1:0] cnt_reg;
    logic [DVD_W-1:0]     dvd_reg;
    logic [WORD_W:0]      rem_reg;
    logic [WORD_W-1:0]    dsr_reg;
    logic                 neg_reg;

    logic [DIFF_W-1:0] dvd_mag;
    logic [WORD_W-1:0] dsr_mag;
    logic [WORD_W:0]   rem_sh;
    logic              rem_ge;
    logic [WORD_W:0]   rem_step;

    assign dvd_mag = dividend[DIFF_W-1] ? DIFF_W'(-dividend) : dividend;
    assign dsr_mag = divisor[WORD_W-1] ? WORD_W'(-divisor) : divisor;

    assign rem_sh   = {rem_reg[WORD_W-1:0], dvd_reg[DVD_W-1]};
    assign rem_ge   = rem_sh >= {1'b0, dsr_reg};
    assign rem_step = rem_ge ? (rem_sh - {1'b0, dsr_reg}) : rem_sh;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            fin_reg <= busy_reg && (cnt_reg == CNT_LAST);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // The dividend register shifts out the dividend and shifts in the quotient.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= DVD_W'(dvd_mag) << FRAC_BITS;
            rem_reg <= '0;
            dsr_reg <= dsr_mag;
            neg_reg <= dividend[DIFF_W-1] ^ divisor[WORD_W-1];
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_step;
            dvd_reg <= {dvd_reg[DVD_W-2:0], rem_ge};
        end
    end

    always_comb
    begin
        res.done = fin_reg;
        if (neg_reg)
        begin
            res.sat      = dvd_reg > NEG_LIM;
            res.quotient = res.sat ? WORD_MIN : WORD_W'(-dvd_reg);
        end
        else
        begin
            res.sat      = dvd_reg > POS_LIM;
            res.quotient = res.sat ? WORD_MAX : dvd_reg[WORD_W-1:0];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/npe_mul.sv =====
// Two-stage Q-format multiplier: exact product, then floor shift and clip.
`default_nettype none

module npe_mul (
    input  wire logic                              clk,
    input  wire logic signed [npe_pkg::WORD_W-1:0] a,
    input  wire logic signed [npe_pkg::WORD_W-1:0] b,
    output npe_pkg::word_res_t                     res
);
    import npe_pkg::*;

    logic signed [63:0] prod_reg;
    word_res_t          res_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
        // Arithmetic shift drops the fraction bits rounding toward minus infinity.
        res_reg  <= clip_word(prod_reg >>> FRAC_BITS);
    end

    assign res = res_reg;

endmodule

`default_nettype wire
